### rtl/totp_pkg.sv
package totp_pkg;

  localparam int KeyWords = 8;
  localparam int CfgIdxW = 3;
  localparam logic [63:0] TimeStep = 64'd30;
  localparam logic [19:0] CodeMod = 20'd1000000;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [7:0] IPad = 8'h36;
  localparam logic [7:0] OPad = 8'h5c;

  // Message length in bits, for the padding of each hash
  localparam logic [63:0] InnerBits = 64'd576;
  localparam logic [63:0] OuterBits = 64'd672;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    begin
      if (rnd < 7'd20) k = 32'h5A827999;
      else if (rnd < 7'd40) k = 32'h6ED9EBA1;
      else if (rnd < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
    end
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      if (rnd < 7'd20) f = (b & c) | (~b & d);
      else if (rnd >= 7'd40 && rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
    end
  endfunction

endpackage

### rtl/totp_sha1_core.sv
// SHA-1 compression of one 512-bit block, one round per cycle.
// The message schedule is a 16-word shift register that advances once a round.
module totp_sha1_core import totp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [159:0] h_in,
  input  logic [511:0] block,
  output logic         done,
  output logic [159:0] h_out
);

  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [159:0] hin_r;
  logic [6:0] rnd_r;
  logic busy_r;
  logic done_r;
  logic [31:0] w_new, t_sum;

  assign w_new = {w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]} << 1 |
                 {w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]} >> 31;
  assign t_sum = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r +
                 round_k(rnd_r) + w_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= busy_r && (rnd_r == 7'd79);
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        hin_r  <= h_in;
        {a_r, b_r, c_r, d_r, e_r} <= h_in;
        for (int i = 0; i < 16; i++) w_r[i] <= block[511-32*i -: 32];
      end else if (busy_r) begin
        a_r <= t_sum;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd79) busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign h_out = {hin_r[159:128] + a_r, hin_r[127:96] + b_r, hin_r[95:64] + c_r,
                  hin_r[63:32] + d_r, hin_r[31:0] + e_r};

endmodule

### rtl/totp_code_generator.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | in_unix_seconds[63:0]
// out     | output    | out_valid/out_ready | out_code[19:0]
// cfg     | input     | cfg_we              | cfg_index[2:0], cfg_data[63:0]
// Each item passes through a bit-serial divide by 30, four SHA-1 blocks on
// one shared round unit, a truncation step and a bit-serial modulo 1000000.
// Reset is synchronous; the key resets to zero.
// in_ready is low while an item is in work or its code waits on out_ready.
module totp_code_generator import totp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [63:0]  in_unix_seconds,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [19:0]  out_code,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_IN1, S_IN2, S_OUT1, S_OUT2, S_TRUNC, S_MOD, S_DONE
  } state_t;

  state_t state_r;
  logic [63:0] key_r [KeyWords];
  logic [63:0] quo_r;
  logic [4:0]  rem_r;
  logic [6:0]  cnt_r;
  logic [159:0] h_r, ih_r;
  logic        started_r;
  logic [31:0] bin_r;
  logic [19:0] mrem_r;
  logic        core_start;
  logic [511:0] core_blk, kx_blk;
  logic        core_done;
  logic [159:0] core_h;
  logic [5:0]  rem_sh;
  logic [20:0] mrem_sh;
  logic [3:0]  off;
  logic [7:0]  mbyte [20];

  always_comb begin
    kx_blk = '0;
    for (int i = 0; i < KeyWords; i++) begin
      for (int j = 0; j < 8; j++) begin
        kx_blk[511-64*i-8*j -: 8] = key_r[i][63-8*j -: 8] ^
          ((state_r == S_IN1) ? IPad : OPad);
      end
    end
    case (state_r)
      S_IN2:   core_blk = {quo_r, 8'h80, 376'd0, InnerBits};
      S_OUT2:  core_blk = {ih_r, 8'h80, 280'd0, OuterBits};
      default: core_blk = kx_blk;
    endcase
  end

  assign core_start = (state_r == S_IN1 || state_r == S_IN2 || state_r == S_OUT1 ||
                       state_r == S_OUT2) && !started_r;

  totp_sha1_core u_core (
    .clk(clk), .rst_n(rst_n), .start(core_start), .h_in(h_r), .block(core_blk),
    .done(core_done), .h_out(core_h)
  );

  assign rem_sh = {rem_r, quo_r[63]};
  assign mrem_sh = {mrem_r, bin_r[31]};
  assign off = h_r[3:0];
  always_comb begin
    for (int i = 0; i < 20; i++) mbyte[i] = h_r[159-8*i -: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KeyWords; i++) key_r[i] <= '0;
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) key_r[cfg_index] <= cfg_data;
      case (state_r)
        S_IDLE: if (in_valid) begin
          quo_r   <= in_unix_seconds;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= 6'(TimeStep)) begin
            rem_r <= 5'(rem_sh - 6'(TimeStep));
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh[4:0];
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            h_r <= {H0, H1, H2, H3, H4};
            state_r <= S_IN1;
          end
        end
        S_IN1, S_IN2, S_OUT1, S_OUT2: begin
          if (core_start) started_r <= 1'b1;
          if (core_done) begin
            started_r <= 1'b0;
            case (state_r)
              S_IN1: begin
                h_r <= core_h;
                state_r <= S_IN2;
              end
              S_IN2: begin
                ih_r <= core_h;
                h_r <= {H0, H1, H2, H3, H4};
                state_r <= S_OUT1;
              end
              S_OUT1: begin
                h_r <= core_h;
                state_r <= S_OUT2;
              end
              default: begin
                h_r <= core_h;
                state_r <= S_TRUNC;
              end
            endcase
          end
        end
        S_TRUNC: begin
          bin_r <= {1'b0, mbyte[5'(off)][6:0], mbyte[5'(off)+5'd1], mbyte[5'(off)+5'd2],
                    mbyte[5'(off)+5'd3]};
          mrem_r <= '0;
          cnt_r <= '0;
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (mrem_sh >= 21'(CodeMod)) mrem_r <= 20'(mrem_sh - 21'(CodeMod));
          else mrem_r <= mrem_sh[19:0];
          bin_r <= {bin_r[30:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd31) state_r <= S_DONE;
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_code = mrem_r;

endmodule

### rtl/totp_checker.sv
module totp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] out_code
);

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code < 20'd1000000) else $error("code out of range");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while code pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("code dropped");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("no work after accept");

endmodule

bind totp_code_generator totp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_code(out_code)
);
